FILE: design/prpi_pkg.sv
package prpi_pkg;

   localparam int MAX_STEPS_DEF = 32;

   localparam logic [31:0] REF_RES_RST   = 32'd65536;
   localparam logic [30:0] MIN_SWING_RST = 31'd256;

   // cap on the interpolation term magnitude and the variance ceiling
   localparam logic [41:0] TERM_CAP = 42'h200_0000_0000;
   localparam logic [47:0] SAT_VAR  = 48'hFFFF_FFFF_FFFF;
   localparam logic signed [43:0] RESP_MAX = 44'sh07F_FFFF_FFFF;
   localparam logic signed [43:0] RESP_MIN = -44'sh080_0000_0000;

   // register indexes
   localparam logic CSR_REF_RES   = 1'b0;
   localparam logic CSR_MIN_SWING = 1'b1;

   // result register operations
   localparam logic [2:0] RES_NONE = 3'd0;
   localparam logic [2:0] RES_CLR  = 3'd1;
   localparam logic [2:0] RES_RESP = 3'd2;
   localparam logic [2:0] RES_VAR1 = 3'd3;
   localparam logic [2:0] RES_VAR3 = 3'd4;

   // multiply-divide operand select
   localparam logic [1:0] MD_SEL_DR = 2'd0;
   localparam logic [1:0] MD_SEL_VS = 2'd1;
   localparam logic [1:0] MD_SEL_T  = 2'd2;

   typedef struct packed {
      logic       load_en;
      logic       clr_pixel;
      logic       set_bad;
      logic       mul_ref;
      logic       cap_p;
      logic       cap_a;
      logic       cap_b;
      logic       swing_a;
      logic       swing_chk;
      logic [2:0] res_op;
      logic       md_start;
      logic [1:0] md_sel;
   } cmd_type;

   typedef struct packed {
      logic pixel_bad;
      logic p_lt;
      logic p_le;
      logic den_zero;
      logic vok;
      logic md_done;
      logic t_sat;
   } stat_type;

endpackage

FILE: design/prpi_muldiv.sv
module prpi_muldiv import prpi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   a,
   input  logic [63:0]   m,
   input  logic [63:0]   d,
   output logic          busy,
   output logic [127:0]  q,
   output logic [63:0]   rem
);

   localparam int MUL_STEPS = 64;
   localparam int DIV_STEPS = 128;

   logic         busy_ff, busy_in;
   logic         div_ff, div_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  a_ff, a_in;
   logic [63:0]  m_ff, m_in;
   logic [63:0]  d_ff, d_in;
   logic [63:0]  r_ff, r_in;
   logic [64:0]  rr;
   logic [64:0]  diff;
   logic         ge;

   assign rr   = {r_ff, acc_ff[127]};
   assign ge   = rr >= {1'b0, d_ff};
   assign diff = rr - {1'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      m_in    = m_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         div_in  = 1'b0;
         cnt_in  = '0;
         acc_in  = '0;
         a_in    = a;
         m_in    = m;
         d_in    = d;
         r_in    = '0;
      end else if (busy_ff && !div_ff) begin
         // shift-add multiply, msb of a first
         acc_in = {acc_ff[126:0], 1'b0} + (a_ff[63] ? {64'd0, m_ff} : 128'd0);
         a_in   = {a_ff[62:0], 1'b0};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(MUL_STEPS - 1)) begin
            div_in = 1'b1;
            cnt_in = '0;
         end
      end else if (busy_ff) begin
         // restoring divide, quotient bits shift in from the bottom
         r_in   = ge ? diff[63:0] : rr[63:0];
         acc_in = {acc_ff[126:0], ge};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         div_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         div_ff  <= div_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      m_ff   <= m_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
   end

   assign busy = busy_ff;
   assign q    = acc_ff;
   assign rem  = r_ff;

endmodule

FILE: design/prpi_dp.sv
module prpi_dp import prpi_pkg::*; #(
   parameter int MAX_STEPS = MAX_STEPS_DEF,
   parameter int IDXW      = $clog2(MAX_STEPS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic [15:0]         heater_setting,
   input  logic [31:0]         pixel_resistance,
   input  logic                resistance_good,
   input  logic signed [31:0]  response,
   input  logic                response_good,
   input  logic [31:0]         response_variance,
   input  logic                variance_good,
   input  logic [IDXW-1:0]     mem_addr,
   input  cmd_type             cmd,
   output stat_type            stat,
   output logic [63:0]         ref_power,
   output logic signed [39:0]  std_response,
   output logic                std_response_good,
   output logic [47:0]         std_variance,
   output logic                std_variance_good
);

   logic [15:0]        set_mem  [MAX_STEPS];
   logic signed [31:0] resp_mem [MAX_STEPS];
   logic [31:0]        var_mem  [MAX_STEPS];
   logic               vok_mem  [MAX_STEPS];

   logic [15:0]        rd_set_ff;
   logic signed [31:0] rd_resp_ff;
   logic [31:0]        rd_var_ff;
   logic               rd_vok_ff;

   logic [31:0] ref_ff;
   logic [30:0] min_swing_ff;
   logic [31:0] held_ff;
   logic        bad_ff;

   logic [31:0] sq_ff;
   logic [63:0] prod_ff;
   logic [63:0] p_ff;
   logic [63:0] pwa_ff;
   logic signed [31:0] ra_ff;
   logic [31:0] va_ff;
   logic        voka_ff;
   logic [63:0] num_ff, den_ff;
   logic        nneg_ff, dneg_ff;
   logic signed [32:0] dr_ff;
   logic [32:0] vs_ff;
   logic        vok_ff;
   logic [47:0] t_ff;

   logic signed [39:0] res_resp_ff;
   logic               res_rgood_ff;
   logic [47:0]        res_var_ff;
   logic               res_vgood_ff;

   logic [63:0]  md_a;
   logic         md_busy;
   logic [127:0] md_q;
   logic [63:0]  md_rem;

   logic signed [32:0] swing;
   logic [32:0]        swing_mag;
   logic [32:0]        dr_mag;
   logic               capped;
   logic               rnd;
   logic [41:0]        mag;
   logic signed [43:0] sum;
   logic               hi_nz;
   logic [48:0]        var_sum;

   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         set_mem[mem_addr]  <= heater_setting;
         resp_mem[mem_addr] <= response;
         var_mem[mem_addr]  <= response_variance;
         vok_mem[mem_addr]  <= variance_good;
      end
      rd_set_ff  <= set_mem[mem_addr];
      rd_resp_ff <= resp_mem[mem_addr];
      rd_var_ff  <= var_mem[mem_addr];
      rd_vok_ff  <= vok_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff       <= REF_RES_RST;
         min_swing_ff <= MIN_SWING_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_REF_RES:   ref_ff       <= csr_wdata;
            CSR_MIN_SWING: min_swing_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign swing     = {ra_ff[31], ra_ff} - {rd_resp_ff[31], rd_resp_ff};
   assign swing_mag = swing[32] ? 33'(-swing) : 33'(swing);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         bad_ff  <= 1'b0;
      end else if (cmd.clr_pixel) begin
         held_ff <= '0;
         bad_ff  <= 1'b0;
      end else begin
         if (cmd.load_en) begin
            held_ff <= pixel_resistance;
            if (!resistance_good || !response_good) bad_ff <= 1'b1;
         end
         if (cmd.set_bad) bad_ff <= 1'b1;
         if (cmd.swing_chk && swing_mag < {2'b00, min_swing_ff}) bad_ff <= 1'b1;
      end
   end

   // setting squared, then times the selected resistance
   always_ff @(posedge clock) begin
      sq_ff   <= 32'(rd_set_ff * rd_set_ff);
      prod_ff <= 64'(sq_ff * (cmd.mul_ref ? ref_ff : held_ff));
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_p) p_ff <= prod_ff;
      if (cmd.swing_a) ra_ff <= rd_resp_ff;
      if (cmd.cap_a) begin
         pwa_ff  <= prod_ff;
         ra_ff   <= rd_resp_ff;
         va_ff   <= rd_var_ff;
         voka_ff <= rd_vok_ff;
      end
      if (cmd.cap_b) begin
         if (prod_ff >= pwa_ff) begin
            den_ff  <= prod_ff - pwa_ff;
            dneg_ff <= 1'b0;
         end else begin
            den_ff  <= pwa_ff - prod_ff;
            dneg_ff <= 1'b1;
         end
         if (p_ff >= pwa_ff) begin
            num_ff  <= p_ff - pwa_ff;
            nneg_ff <= 1'b0;
         end else begin
            num_ff  <= pwa_ff - p_ff;
            nneg_ff <= 1'b1;
         end
         dr_ff  <= {rd_resp_ff[31], rd_resp_ff} - {ra_ff[31], ra_ff};
         vs_ff  <= {1'b0, va_ff} + {1'b0, rd_var_ff};
         vok_ff <= voka_ff & rd_vok_ff;
      end
   end

   assign dr_mag = dr_ff[32] ? 33'(-dr_ff) : 33'(dr_ff);

   always_comb begin
      case (cmd.md_sel)
         MD_SEL_DR: md_a = {31'd0, dr_mag};
         MD_SEL_VS: md_a = {31'd0, vs_ff};
         MD_SEL_T:  md_a = {16'd0, t_ff};
         default:   md_a = '0;
      endcase
   end

   prpi_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (cmd.md_start),
      .a     (md_a),
      .m     (num_ff),
      .d     (den_ff),
      .busy  (md_busy),
      .q     (md_q),
      .rem   (md_rem)
   );

   // round to nearest, ties away from zero, then apply sign and saturate
   assign capped = (|md_q[127:64]) || (md_q[63:0] > {22'd0, TERM_CAP});
   assign rnd    = md_rem >= (den_ff - md_rem);
   assign mag    = capped ? TERM_CAP : md_q[41:0] + {41'd0, rnd};

   always_comb begin
      if (dr_ff[32] ^ nneg_ff ^ dneg_ff) begin
         sum = 44'(ra_ff) - $signed({2'b00, mag});
      end else begin
         sum = 44'(ra_ff) + $signed({2'b00, mag});
      end
   end

   assign hi_nz   = |md_q[127:48];
   assign var_sum = {17'd0, va_ff} + {1'b0, md_q[47:0]};

   always_ff @(posedge clock) begin
      case (cmd.res_op)
         RES_CLR: begin
            res_resp_ff  <= '0;
            res_rgood_ff <= 1'b0;
            res_var_ff   <= '0;
            res_vgood_ff <= 1'b0;
         end
         RES_RESP: begin
            res_rgood_ff <= 1'b1;
            if (sum > RESP_MAX) begin
               res_resp_ff <= RESP_MAX[39:0];
            end else if (sum < RESP_MIN) begin
               res_resp_ff <= RESP_MIN[39:0];
            end else begin
               res_resp_ff <= sum[39:0];
            end
         end
         RES_VAR1: begin
            res_vgood_ff <= 1'b1;
            t_ff         <= md_q[47:0];
            if (hi_nz) res_var_ff <= SAT_VAR;
         end
         RES_VAR3: begin
            if (hi_nz || var_sum[48]) begin
               res_var_ff <= SAT_VAR;
            end else begin
               res_var_ff <= var_sum[47:0];
            end
         end
         default: ;
      endcase
   end

   assign stat.pixel_bad = bad_ff;
   assign stat.p_lt      = p_ff < prod_ff;
   assign stat.p_le      = p_ff <= prod_ff;
   assign stat.den_zero  = den_ff == '0;
   assign stat.vok       = vok_ff;
   assign stat.md_done   = !md_busy;
   assign stat.t_sat     = hi_nz;

   assign ref_power         = p_ff;
   assign std_response      = res_resp_ff;
   assign std_response_good = res_rgood_ff;
   assign std_variance      = res_var_ff;
   assign std_variance_good = res_vgood_ff;

endmodule

FILE: design/prpi_ctrl.sv
module prpi_ctrl import prpi_pkg::*; #(
   parameter int MAX_STEPS = MAX_STEPS_DEF,
   parameter int IDXW      = $clog2(MAX_STEPS)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic            req_tlast,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic            rsp_tlast,
   output logic [IDXW-1:0] mem_addr,
   output cmd_type         cmd,
   input  stat_type        stat
);

   localparam int CW = $clog2(MAX_STEPS + 1);

   localparam logic [4:0] S_LOAD    = 5'd0;
   localparam logic [4:0] S_SW0     = 5'd1;
   localparam logic [4:0] S_SW1     = 5'd2;
   localparam logic [4:0] S_SW2     = 5'd3;
   localparam logic [4:0] S_FETCH   = 5'd4;
   localparam logic [4:0] S_GOT_P   = 5'd5;
   localparam logic [4:0] S_GOT_PW0 = 5'd6;
   localparam logic [4:0] S_GOT_PWK = 5'd7;
   localparam logic [4:0] S_GOT_A   = 5'd8;
   localparam logic [4:0] S_GOT_B   = 5'd9;
   localparam logic [4:0] S_SEG     = 5'd10;
   localparam logic [4:0] S_MD_R    = 5'd11;
   localparam logic [4:0] S_V1      = 5'd12;
   localparam logic [4:0] S_MD_V1   = 5'd13;
   localparam logic [4:0] S_V3      = 5'd14;
   localparam logic [4:0] S_MD_V3   = 5'd15;
   localparam logic [4:0] S_EMIT    = 5'd16;

   logic [4:0]      state_ff, state_in;
   logic [4:0]      ret_ff, ret_in;
   logic [1:0]      ph_ff, ph_in;
   logic [IDXW-1:0] addr_ff, addr_in;
   logic            mul_ref_ff, mul_ref_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [IDXW-1:0] j_ff, j_in;
   logic [IDXW-1:0] k_ff, k_in;
   logic [IDXW-1:0] b_ff, b_in;
   logic [IDXW-1:0] n_last;

   assign n_last = IDXW'(cnt_ff - CW'(1));

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      ph_in      = ph_ff;
      addr_in    = addr_ff;
      mul_ref_in = mul_ref_ff;
      cnt_in     = cnt_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      b_in       = b_ff;
      cmd        = '0;
      cmd.mul_ref = mul_ref_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tlast  = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (cnt_ff < CW'(MAX_STEPS)) begin
                  cmd.load_en = 1'b1;
                  cnt_in      = cnt_ff + CW'(1);
               end
               if (req_tlast) begin
                  addr_in  = '0;
                  state_in = S_SW0;
               end
            end
         end
         S_SW0: begin
            if (cnt_ff < CW'(2)) cmd.set_bad = 1'b1;
            addr_in  = n_last;
            state_in = S_SW1;
         end
         S_SW1: begin
            cmd.swing_a = 1'b1;
            state_in    = S_SW2;
         end
         S_SW2: begin
            cmd.swing_chk = 1'b1;
            j_in       = '0;
            addr_in    = '0;
            mul_ref_in = 1'b1;
            ret_in     = S_GOT_P;
            ph_in      = '0;
            state_in   = S_FETCH;
         end
         // fetch steps in order: memory read, square, times resistance
         S_FETCH: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd2) begin
               ph_in    = '0;
               state_in = ret_ff;
            end
         end
         S_GOT_P: begin
            cmd.cap_p  = 1'b1;
            cmd.res_op = RES_CLR;
            if (stat.pixel_bad) begin
               state_in = S_EMIT;
            end else begin
               addr_in    = '0;
               mul_ref_in = 1'b0;
               ret_in     = S_GOT_PW0;
               state_in   = S_FETCH;
            end
         end
         S_GOT_PW0: begin
            if (stat.p_lt) begin
               b_in    = '0;
               addr_in = '0;
               ret_in  = S_GOT_A;
            end else begin
               k_in    = IDXW'(1);
               addr_in = IDXW'(1);
               ret_in  = S_GOT_PWK;
            end
            state_in = S_FETCH;
         end
         S_GOT_PWK: begin
            if (stat.p_le || k_ff == n_last) begin
               b_in    = k_ff - IDXW'(1);
               addr_in = k_ff - IDXW'(1);
               ret_in  = S_GOT_A;
            end else begin
               k_in    = k_ff + IDXW'(1);
               addr_in = k_ff + IDXW'(1);
               ret_in  = S_GOT_PWK;
            end
            state_in = S_FETCH;
         end
         S_GOT_A: begin
            cmd.cap_a = 1'b1;
            addr_in   = b_ff + IDXW'(1);
            ret_in    = S_GOT_B;
            state_in  = S_FETCH;
         end
         S_GOT_B: begin
            cmd.cap_b = 1'b1;
            state_in  = S_SEG;
         end
         S_SEG: begin
            if (stat.den_zero) begin
               state_in = S_EMIT;
            end else begin
               cmd.md_start = 1'b1;
               cmd.md_sel   = MD_SEL_DR;
               state_in     = S_MD_R;
            end
         end
         S_MD_R: begin
            cmd.md_sel = MD_SEL_DR;
            if (stat.md_done) begin
               cmd.res_op = RES_RESP;
               state_in   = stat.vok ? S_V1 : S_EMIT;
            end
         end
         S_V1: begin
            cmd.md_start = 1'b1;
            cmd.md_sel   = MD_SEL_VS;
            state_in     = S_MD_V1;
         end
         S_MD_V1: begin
            cmd.md_sel = MD_SEL_VS;
            if (stat.md_done) begin
               cmd.res_op = RES_VAR1;
               state_in   = stat.t_sat ? S_EMIT : S_V3;
            end
         end
         S_V3: begin
            cmd.md_start = 1'b1;
            cmd.md_sel   = MD_SEL_T;
            state_in     = S_MD_V3;
         end
         S_MD_V3: begin
            cmd.md_sel = MD_SEL_T;
            if (stat.md_done) begin
               cmd.res_op = RES_VAR3;
               state_in   = S_EMIT;
            end
         end
         S_EMIT: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = j_ff == n_last;
            if (rsp_tready) begin
               if (j_ff == n_last) begin
                  cmd.clr_pixel = 1'b1;
                  cnt_in        = '0;
                  state_in      = S_LOAD;
               end else begin
                  j_in       = j_ff + IDXW'(1);
                  addr_in    = j_ff + IDXW'(1);
                  mul_ref_in = 1'b1;
                  ret_in     = S_GOT_P;
                  state_in   = S_FETCH;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   assign mem_addr = (state_ff == S_LOAD) ? cnt_ff[IDXW-1:0] : addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         ph_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         cnt_ff   <= cnt_in;
      end
      ret_ff     <= ret_in;
      addr_ff    <= addr_in;
      mul_ref_ff <= mul_ref_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      b_ff       <= b_in;
   end

endmodule

FILE: design/pixel_response_power_interpolator_unit.sv
// channel   dir  transfer when          payload
// req_      in   tvalid & tready        tdata, tuser (good marks), tlast (last ramp step)
// rsp_      out  tvalid & tready        tdata, tuser (good marks), tlast (last result)
// csr_      in   wr_en                  index, wdata
//
// a ramp step is taken whenever one is offered while loading; the step that closes
// the ramp starts the emit pass after the swing check; each result fetches its own
// setting, each power compared in the segment search and both segment ends, then makes
// up to three passes through the shared shift-add multiply / restoring divide unit, then
// presents it until transferred (less work for bad pixels, zero spans, invalid variance)
// no new step is taken until the last result of the pixel has been transferred
// reset is synchronous; the step stores keep no reset and need none
module pixel_response_power_interpolator_unit import prpi_pkg::*; #(
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // heater_setting, pixel_resistance, response, response_variance
   input  logic [111:0]  req_tdata,
   // resistance_good, response_good, variance_good
   input  logic [2:0]    req_tuser,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // ref_power, std_response, std_variance
   output logic [151:0]  rsp_tdata,
   // std_response_good, std_variance_good
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast,
   input  logic          csr_wr_en,
   input  logic          csr_index,
   input  logic [31:0]   csr_wdata
);

   localparam int IDXW = $clog2(MAX_STEPS);

   cmd_type            cmd;
   stat_type           stat;
   logic [IDXW-1:0]    mem_addr;
   logic [63:0]        ref_power;
   logic signed [39:0] std_response;
   logic               std_response_good;
   logic [47:0]        std_variance;
   logic               std_variance_good;

   prpi_ctrl #(.MAX_STEPS(MAX_STEPS), .IDXW(IDXW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .mem_addr   (mem_addr),
      .cmd        (cmd),
      .stat       (stat)
   );

   prpi_dp #(.MAX_STEPS(MAX_STEPS), .IDXW(IDXW)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .heater_setting    (req_tdata[15:0]),
      .pixel_resistance  (req_tdata[47:16]),
      .resistance_good   (req_tuser[0]),
      .response          (req_tdata[79:48]),
      .response_good     (req_tuser[1]),
      .response_variance (req_tdata[111:80]),
      .variance_good     (req_tuser[2]),
      .mem_addr          (mem_addr),
      .cmd               (cmd),
      .stat              (stat),
      .ref_power         (ref_power),
      .std_response      (std_response),
      .std_response_good (std_response_good),
      .std_variance      (std_variance),
      .std_variance_good (std_variance_good)
   );

   assign rsp_tdata = {std_variance, std_response, ref_power};
   assign rsp_tuser = {std_variance_good, std_response_good};

endmodule

FILE: test/pixel_response_power_interpolator_unit_checker.sv
`timescale 1ns / 1ps

module pixel_response_power_interpolator_unit_checker import prpi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [111:0]  req_tdata,
   input  logic [2:0]    req_tuser,
   input  logic          req_tlast,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [151:0]  rsp_tdata,
   input  logic [1:0]    rsp_tuser,
   input  logic          rsp_tlast,
   input  logic          csr_wr_en,
   input  logic          csr_index,
   input  logic [31:0]   csr_wdata,
   output int            fail_count,
   output int            pending,
   output int            results_seen
);

   localparam int DEPTH = MAX_STEPS_DEF;
   localparam longint SAT_HI = 64'sd549755813887;
   localparam longint SAT_LO = -64'sd549755813888;

   typedef struct packed {
      logic [63:0] power;
      logic [39:0] resp;
      logic        resp_ok;
      logic [47:0] varc;
      logic        var_ok;
      logic        last;
   } std_result_t;

   std_result_t  std_results[$];

   logic [31:0]  ref_res;
   logic [30:0]  swing_min;
   logic [15:0]  set_mem[DEPTH];
   logic [31:0]  resp_mem[DEPTH];
   logic [31:0]  var_mem[DEPTH];
   logic         vok_mem[DEPTH];
   logic [31:0]  pix_res;
   int           nsteps;
   logic         bad_flag;

   // standardize the held ramp at the reference power, one result per step
   task automatic standardize_pixel();
      logic [63:0]   pw[DEPTH];
      logic [63:0]   sq, pref, num, den, drm, mag, vs, u, vsum;
      logic [127:0]  prod, quo, rem, t, uu;
      logic          bad, nneg, dneg, drneg, sat;
      longint        sw, dr, r;
      int            b;
      std_result_t   e;
      bad = bad_flag || nsteps < 2;
      if (!bad) begin
         sw = longint'($signed(resp_mem[0])) - longint'($signed(resp_mem[nsteps-1]));
         if (sw < 0) sw = -sw;
         if (sw < longint'({33'd0, swing_min})) bad = 1'b1;
      end
      for (int j = 0; j < nsteps; j++) begin
         sq = {48'd0, set_mem[j]} * {48'd0, set_mem[j]};
         pw[j] = sq * {32'd0, pix_res};
      end
      for (int j = 0; j < nsteps; j++) begin
         sq = {48'd0, set_mem[j]} * {48'd0, set_mem[j]};
         pref = sq * {32'd0, ref_res};
         e = '0;
         e.power = pref;
         e.last = (j == nsteps - 1);
         if (!bad) begin
            if (pref < pw[0]) b = 0;
            else if (pref > pw[nsteps-1]) b = nsteps - 2;
            else begin
               b = nsteps - 2;
               for (int k = 1; k < nsteps; k++)
                  if (pref <= pw[k]) begin
                     b = k - 1;
                     break;
                  end
            end
            nneg = pref < pw[b];
            num = nneg ? pw[b] - pref : pref - pw[b];
            dneg = pw[b+1] < pw[b];
            den = dneg ? pw[b] - pw[b+1] : pw[b+1] - pw[b];
            if (den != 0) begin
               e.resp_ok = 1'b1;
               dr = longint'($signed(resp_mem[b+1])) - longint'($signed(resp_mem[b]));
               drneg = dr < 0;
               drm = drneg ? -dr : dr;
               prod = {64'd0, drm} * {64'd0, num};
               quo = prod / {64'd0, den};
               rem = prod % {64'd0, den};
               if (quo > {86'd0, TERM_CAP}) mag = {22'd0, TERM_CAP};
               else begin
                  mag = quo[63:0];
                  if (rem[63:0] >= den - rem[63:0]) mag = mag + 1;
               end
               r = longint'($signed(resp_mem[b]));
               r = (drneg ^ nneg ^ dneg) ? r - longint'(mag) : r + longint'(mag);
               if (r > SAT_HI) r = SAT_HI;
               if (r < SAT_LO) r = SAT_LO;
               e.resp = r[39:0];
               if (vok_mem[b] && vok_mem[b+1]) begin
                  e.var_ok = 1'b1;
                  vs = {32'd0, var_mem[b]} + {32'd0, var_mem[b+1]};
                  t = ({64'd0, vs} * {64'd0, num}) / {64'd0, den};
                  sat = t >= (128'd1 << 48);
                  u = 0;
                  if (!sat) begin
                     uu = ({64'd0, t[63:0]} * {64'd0, num}) / {64'd0, den};
                     if (uu > {80'd0, SAT_VAR}) sat = 1'b1;
                     else u = uu[63:0];
                  end
                  vsum = {32'd0, var_mem[b]} + u;
                  e.varc = (sat || vsum > {16'd0, SAT_VAR}) ? SAT_VAR : vsum[47:0];
               end
            end
         end
         std_results.push_back(e);
      end
      nsteps = 0;
      bad_flag = 1'b0;
      pix_res = '0;
   endtask

   always @(posedge clock) begin
      std_result_t got, want;
      if (reset) begin
         ref_res <= REF_RES_RST;
         swing_min <= MIN_SWING_RST;
         nsteps = 0;
         bad_flag = 1'b0;
         pix_res = '0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_REF_RES) ref_res <= csr_wdata;
            else swing_min <= csr_wdata[30:0];
         end
         if (req_tvalid && req_tready) begin
            if (nsteps < DEPTH) begin
               set_mem[nsteps] = req_tdata[15:0];
               pix_res = req_tdata[47:16];
               resp_mem[nsteps] = req_tdata[79:48];
               var_mem[nsteps] = req_tdata[111:80];
               vok_mem[nsteps] = req_tuser[2];
               if (!req_tuser[0] || !req_tuser[1]) bad_flag = 1'b1;
               nsteps++;
            end
            if (req_tlast) standardize_pixel();
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got = {rsp_tdata[63:0], rsp_tdata[103:64], rsp_tuser[0], rsp_tdata[151:104],
                   rsp_tuser[1], rsp_tlast};
            if (std_results.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result transfer %h", $realtime, got);
            end else begin
               want = std_results.pop_front();
               if (got.power !== want.power || got.resp !== want.resp
                   || got.resp_ok !== want.resp_ok || got.varc !== want.varc
                   || got.var_ok !== want.var_ok || got.last !== want.last) begin
                  fail_count++;
                  $display("%0t: mismatch expected pwr=%h resp=%h rok=%b var=%h vok=%b last=%b",
                           $realtime, want.power, want.resp, want.resp_ok, want.varc,
                           want.var_ok, want.last);
                  $display("%0t:          actual   pwr=%h resp=%h rok=%b var=%h vok=%b last=%b",
                           $realtime, got.power, got.resp, got.resp_ok, got.varc,
                           got.var_ok, got.last);
               end
            end
         end
      end
      pending = std_results.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      results_seen = 0;
   end

endmodule

FILE: test/pixel_response_power_interpolator_unit_tb.sv
`timescale 1ns / 1ps

module pixel_response_power_interpolator_unit_tb import prpi_pkg::*;;

   localparam int  TARGET_ITEMS = 360;
   localparam longint CYCLE_LIMIT = 3_000_000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [111:0]  req_tdata = '0;
   logic [2:0]    req_tuser = '0;
   logic          req_tlast = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [151:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          rsp_tlast;
   logic          csr_wr_en = 1'b0;
   logic          csr_index = CSR_REF_RES;
   logic [31:0]   csr_wdata = '0;

   int            fail_count, pending, results_seen;
   longint        cycles = 0;
   int            items = 0;
   int            pixels = 0;
   int            rsp_hold = 0;
   logic          quiet = 1'b0;
   logic [31:0]   ref_now = REF_RES_RST;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pixel_response_power_interpolator_unit dut (.*);

   pixel_response_power_interpolator_unit_checker checker_i (.*);

   always @(posedge clock) begin
      cycles++;
      if (rsp_tvalid && rsp_tready) rsp_hold = quiet ? 0 : $urandom_range(0, 15);
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_step(input logic [15:0] setting, input logic [31:0] res,
                            input logic [31:0] resp, input logic [31:0] variance,
                            input logic [2:0] marks, input logic last);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {variance, resp, res, setting};
      req_tuser <= marks;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // one write strobe, then the strobe is held low before anything else drives the port
   task automatic write_csr(input logic idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_REF_RES) ref_now = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // one ramp: mostly rising settings, near-linear response, rare bad marks
   task automatic random_pixel(input int len, input bit noisy);
      logic [31:0] res, base, slope, variance;
      logic [15:0] setting;
      logic [2:0]  marks;
      int          stepw;
      res = ($urandom_range(0, 3) != 0) ? ref_now + $urandom_range(0, 4096) - 2048
                                         : $urandom;
      base = $urandom;
      slope = $urandom_range(0, 1) ? $urandom_range(0, 1 << 20) : -$urandom_range(0, 1 << 20);
      setting = 16'($urandom_range(0, 4000));
      stepw = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60000 / (len + 1));
      for (int k = 0; k < len; k++) begin
         variance = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20);
         marks = 3'b111;
         if (noisy || $urandom_range(0, 40) == 0) marks = 3'($urandom);
         else if ($urandom_range(0, 12) == 0) marks[2] = 1'b0;
         send_step(noisy ? 16'($urandom) : setting, res, base + slope * k, variance, marks,
                   k == len - 1);
         setting = setting + stepw[15:0];
      end
      pixels++;
      wait_idle();
   endtask

   initial begin
      int len;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: single step, extremes, bad marks, zero span, bad variance, tiny swing
      send_step(16'd1000, 32'h10000, 32'h7fff_ffff, 32'h1234, 3'b111, 1'b1);
      wait_idle();
      send_step(16'd0, 32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff, 3'b111, 1'b0);
      send_step(16'hffff, 32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 3'b111, 1'b1);
      wait_idle();
      send_step(16'd100, 32'h10000, 32'h0, 32'h100, 3'b111, 1'b0);
      send_step(16'd200, 32'h10000, 32'h5000, 32'h100, 3'b101, 1'b1);
      wait_idle();
      send_step(16'd300, 32'h10000, 32'h0, 32'h100, 3'b111, 1'b0);
      send_step(16'd300, 32'h10000, 32'h9000, 32'h100, 3'b111, 1'b0);
      send_step(16'd500, 32'h10000, 32'h12000, 32'h100, 3'b111, 1'b1);
      wait_idle();
      send_step(16'd10, 32'h0, 32'h100, 32'h200, 3'b011, 1'b0);
      send_step(16'd20, 32'h0, 32'h400, 32'h200, 3'b111, 1'b1);
      wait_idle();
      send_step(16'd50, 32'h20000, 32'h10, 32'h0, 3'b111, 1'b0);
      send_step(16'd90, 32'h18000, 32'h20, 32'h0, 3'b111, 1'b1);
      wait_idle();
      send_step(16'd40, 32'h8000, -32'sd5000, 32'h40, 3'b111, 1'b0);
      send_step(16'd80, 32'h8000, 32'sd9000, 32'h40, 3'b111, 1'b0);
      send_step(16'd160, 32'h8000, 32'sd20000, 32'h40, 3'b110, 1'b1);
      wait_idle();
      send_step(16'd7, 32'h10000, 32'h0, 32'h1, 3'b111, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: begin
               write_csr(CSR_REF_RES, 32'd0);
               write_csr(CSR_MIN_SWING, 32'd0);
            end
            2: begin
               write_csr(CSR_REF_RES, 32'hffff_ffff);
               write_csr(CSR_MIN_SWING, 32'h7fff_ffff);
            end
            3: begin
               write_csr(CSR_REF_RES, $urandom_range(32'h8000, 32'h40000));
               write_csr(CSR_MIN_SWING, $urandom_range(0, 1 << 12));
            end
            default: ;
         endcase
         while (items < 25 + (phase + 1) * (TARGET_ITEMS - 25) / 4) begin
            quiet = $urandom_range(0, 3) == 0;
            case ($urandom_range(0, 29))
               0: len = 1;
               1: len = $urandom_range(33, 36);
               default: len = $urandom_range(2, 8);
            endcase
            random_pixel(len, $urandom_range(0, 9) == 0);
         end
      end
      quiet = 1'b0;
      wait_idle();

      $display("sent %0d ramp steps in %0d pixels under 4 register settings", items, pixels);
      $display("checked %0d standardized results", results_seen);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
